[design/v3alu_pkg.sv]
// ----------------------------------------------------------------------------
// v3alu_pkg
// Shared widths, operation codes, result bundle and saturation helpers for
// the three-component vector unit.
// ----------------------------------------------------------------------------
package v3alu_pkg;

	localparam int WORD_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int MODE_W     = 4;
	localparam int IN_DATA_W  = ((MODE_W + 7 * WORD_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = 4 * WORD_W;
	localparam int OUT_USER_W = 2;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD   = 4'd0,
		MODE_SUB   = 4'd1,
		MODE_NEG   = 4'd2,
		MODE_SCALE = 4'd3,
		MODE_DIV   = 4'd4,
		MODE_DOT   = 4'd5,
		MODE_CROSS = 4'd6,
		MODE_MAG   = 4'd7,
		MODE_NORM  = 4'd8,
		MODE_REFL  = 4'd9
	} mode_t;

	typedef struct packed {
		word_t rx;
		word_t ry;
		word_t rz;
		word_t sc;
		logic  sat;
		logic  err;
	} res_t;

	typedef struct packed {
		word_t val;
		logic  hit;
	} satw_t;

	localparam logic signed [67:0] SAT_MAX = (68'sd1 <<< (WORD_W - 1)) - 68'sd1;
	localparam logic signed [67:0] SAT_MIN = -(68'sd1 <<< (WORD_W - 1));

	// clamp a wide signed value to the word range
	function automatic satw_t sat_word(input logic signed [67:0] v);
		satw_t r;
		if (v > SAT_MAX) begin
			r.val = word_t'(SAT_MAX[WORD_W-1:0]);
			r.hit = 1'b1;
		end else if (v < SAT_MIN) begin
			r.val = word_t'(SAT_MIN[WORD_W-1:0]);
			r.hit = 1'b1;
		end else begin
			r.val = v[WORD_W-1:0];
			r.hit = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] umag(input word_t v);
		logic [WORD_W-1:0] r;
		r = v[WORD_W-1] ? (~v + 1'b1) : v;
		return r;
	endfunction

endpackage

[design/vector3_alu_unit.sv]
// ----------------------------------------------------------------------------
// vector3_alu_unit
// Pipelined Q16.16 vector unit: add, sub, negate, scale, divide, dot, cross,
// magnitude, normalize and reflect, with saturation and error flags.
// ----------------------------------------------------------------------------
// One transaction enters per clock unless the output side stalls; the
// whole pipeline advances whenever the output register is empty or taken, so a
// stall on the output side holds every stage. Most of the depth is the square
// root (32 stages, one root bit each) followed by three parallel restoring
// dividers (33 stages, one quotient bit each) that normalize and divide share;
// all modes travel through the same stages so results stay in order.
module vector3_alu_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// mode[3:0], ax, ay, az, bx, by, bz, factor (32 bits each), zero pad
	input  logic [v3alu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// rx, ry, rz, scalar_result (32 bits each)
	output logic [v3alu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// saturated, error
	output logic [v3alu_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
	import v3alu_pkg::*;

	localparam int SQ_STAGES = WORD_W;
	localparam int DV_STAGES = WORD_W + 1;
	localparam int NUM_W     = WORD_W + FRAC_W + 1;
	localparam logic signed [65:0] HALF66 = 66'sd1 <<< (FRAC_W - 1);

	typedef struct packed {
		logic [MODE_W-1:0]             mode;
		res_t                          res;
		logic [2:0]                    aneg;
		logic [2:0][WORD_W-1:0]        amag;
		logic                          fneg;
		logic [WORD_W-1:0]             fmag;
	} tag_t;

	typedef struct packed {
		tag_t                          tag;
		logic [2*WORD_W-1:0]           rad;
		logic [WORD_W+1:0]             rem;
		logic [WORD_W-1:0]             root;
	} sq_t;

	typedef struct packed {
		tag_t                          tag;
		logic [WORD_W:0]               den;
		logic [2:0][NUM_W-1:0]         num;
		logic [2:0][WORD_W:0]          rem;
		logic [2:0][WORD_W:0]          quo;
		logic [2:0]                    ovf;
	} dv_t;

	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// ---------------- stage 1: input register
	logic              v_s1;
	logic [MODE_W-1:0] mode_s1;
	word_t             a_s1 [3];
	word_t             b_s1 [3];
	word_t             f_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= s_axis_tdata[MODE_W-1:0];
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= s_axis_tdata[MODE_W + i*WORD_W +: WORD_W];
				b_s1[i] <= s_axis_tdata[MODE_W + (i+3)*WORD_W +: WORD_W];
			end
			f_s1 <= s_axis_tdata[MODE_W + 6*WORD_W +: WORD_W];
		end
	end

	// ---------------- stage 2: products
	logic              v_s2;
	logic [MODE_W-1:0] mode_s2;
	word_t             a_s2 [3];
	word_t             b_s2 [3];
	word_t             f_s2;
	logic signed [2*WORD_W-1:0] prod_s2 [6];
	word_t             ma [6];
	word_t             mb [6];

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			ma[k] = a_s1[k % 3];
			mb[k] = b_s1[k % 3];
		end
		case (mode_s1) inside
			MODE_CROSS: begin
				ma[0] = a_s1[1]; mb[0] = b_s1[2];
				ma[1] = a_s1[2]; mb[1] = b_s1[1];
				ma[2] = a_s1[2]; mb[2] = b_s1[0];
				ma[3] = a_s1[0]; mb[3] = b_s1[2];
				ma[4] = a_s1[0]; mb[4] = b_s1[1];
				ma[5] = a_s1[1]; mb[5] = b_s1[0];
			end
			MODE_SCALE: begin
				for (int k = 0; k < 3; k++) mb[k] = f_s1;
			end
			MODE_MAG, MODE_NORM: begin
				for (int k = 0; k < 3; k++) mb[k] = a_s1[k];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2 <= mode_s1;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			f_s2    <= f_s1;
			for (int k = 0; k < 6; k++) prod_s2[k] <= ma[k] * mb[k];
		end
	end

	// ---------------- stage 3: sums, rounding, simple results
	logic              v_s3;
	logic [MODE_W-1:0] mode_s3;
	word_t             a_s3 [3];
	word_t             b_s3 [3];
	word_t             f_s3;
	res_t              res_s3;
	logic signed [49:0] d_s3;
	logic [2*WORD_W-1:0] s2_s3;

	logic signed [65:0] dsum, dq;
	logic signed [65:0] cq [3];
	logic [63:0]        s2sum, pm;
	logic [47:0]        rs;
	logic signed [67:0] sv;
	satw_t              sw;
	word_t              vec [3];
	res_t               res3;

	always_comb begin
		dsum  = 66'(prod_s2[0]) + 66'(prod_s2[1]) + 66'(prod_s2[2]);
		dq    = (dsum + HALF66) >>> FRAC_W;
		s2sum = prod_s2[0] + prod_s2[1] + prod_s2[2];
		for (int i = 0; i < 3; i++)
			cq[i] = (66'(prod_s2[2*i]) - 66'(prod_s2[2*i+1]) + HALF66) >>> FRAC_W;
		res3 = '0;
		for (int i = 0; i < 3; i++) vec[i] = '0;
		pm = '0;
		rs = '0;
		sv = '0;
		sw = '0;
		case (mode_s2) inside
			MODE_ADD: begin
				for (int i = 0; i < 3; i++) begin
					sw = sat_word(68'(a_s2[i]) + 68'(b_s2[i]));
					vec[i] = sw.val;
					res3.sat = res3.sat | sw.hit;
				end
			end
			MODE_SUB: begin
				for (int i = 0; i < 3; i++) begin
					sw = sat_word(68'(a_s2[i]) - 68'(b_s2[i]));
					vec[i] = sw.val;
					res3.sat = res3.sat | sw.hit;
				end
			end
			MODE_NEG: begin
				for (int i = 0; i < 3; i++) begin
					sw = sat_word(-68'(a_s2[i]));
					vec[i] = sw.val;
					res3.sat = res3.sat | sw.hit;
				end
			end
			MODE_SCALE: begin
				// round the magnitude, ties away from zero
				for (int i = 0; i < 3; i++) begin
					pm = prod_s2[i][63] ? 64'(-prod_s2[i]) : 64'(prod_s2[i]);
					rs = 48'((pm + (64'd1 << (FRAC_W - 1))) >> FRAC_W);
					sv = $signed({20'b0, rs});
					if (prod_s2[i][63]) sv = -sv;
					sw = sat_word(sv);
					vec[i] = sw.val;
					res3.sat = res3.sat | sw.hit;
				end
			end
			MODE_DIV: begin
				res3.err = (f_s2 == '0);
			end
			MODE_DOT: begin
				sw = sat_word(68'(dq));
				res3.sc  = sw.val;
				res3.sat = sw.hit;
			end
			MODE_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					sw = sat_word(68'(cq[i]));
					vec[i] = sw.val;
					res3.sat = res3.sat | sw.hit;
				end
			end
			MODE_MAG, MODE_REFL: begin
			end
			MODE_NORM: begin
				res3.err = (s2sum == '0);
			end
			default: begin
				res3.err = 1'b1;
			end
		endcase
		res3.rx = vec[0];
		res3.ry = vec[1];
		res3.rz = vec[2];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s3 <= mode_s2;
			a_s3    <= a_s2;
			b_s3    <= b_s2;
			f_s3    <= f_s2;
			res_s3  <= res3;
			d_s3    <= dq[49:0];
			s2_s3   <= s2sum;
		end
	end

	// ---------------- stage 4: reflect partial products
	logic              v_s4;
	logic [MODE_W-1:0] mode_s4;
	word_t             a_s4 [3];
	word_t             f_s4;
	res_t              res_s4;
	logic [2*WORD_W-1:0] s2_s4;
	logic [55:0]       pl_s4 [3];
	logic [55:0]       ph_s4 [3];
	logic [2:0]        rneg_s4;
	logic [47:0]       dmag;
	logic [WORD_W-1:0] bmag [3];

	always_comb begin
		dmag = d_s3[49] ? 48'(-d_s3) : d_s3[47:0];
		for (int i = 0; i < 3; i++) bmag[i] = umag(b_s3[i]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s4 <= mode_s3;
			a_s4    <= a_s3;
			f_s4    <= f_s3;
			res_s4  <= res_s3;
			s2_s4   <= s2_s3;
			for (int i = 0; i < 3; i++) begin
				pl_s4[i]   <= dmag[23:0] * bmag[i];
				ph_s4[i]   <= dmag[47:24] * bmag[i];
				rneg_s4[i] <= d_s3[49] ^ b_s3[i][WORD_W-1];
			end
		end
	end

	// ---------------- stage 5: reflect result, tag for the long path
	logic                v_s5;
	tag_t                tag_s5;
	logic [2*WORD_W-1:0] s2_s5;
	tag_t                tag5;
	logic [79:0]         pfull;
	logic [64:0]         rr;
	logic [32:0]         rc;
	logic signed [67:0]  term;
	satw_t               sw5;
	word_t               rvec [3];
	logic                rsat;

	always_comb begin
		rsat = 1'b0;
		pfull = '0;
		rr = '0;
		rc = '0;
		term = '0;
		sw5 = '0;
		for (int i = 0; i < 3; i++) begin
			pfull = {ph_s4[i], 24'b0} + 80'(pl_s4[i]);
			rr    = 65'((pfull + (80'd1 << (FRAC_W - 2))) >> (FRAC_W - 1));
			rc    = (rr > (65'd1 << WORD_W)) ? (33'd1 << WORD_W) : rr[32:0];
			term  = $signed({35'b0, rc});
			if (rneg_s4[i]) term = -term;
			sw5   = sat_word(68'(a_s4[i]) - term);
			rvec[i] = sw5.val;
			rsat  = rsat | sw5.hit;
		end
		tag5.mode = mode_s4;
		tag5.res  = res_s4;
		if (mode_s4 == MODE_REFL) begin
			tag5.res.rx  = rvec[0];
			tag5.res.ry  = rvec[1];
			tag5.res.rz  = rvec[2];
			tag5.res.sat = rsat;
		end
		for (int i = 0; i < 3; i++) begin
			tag5.aneg[i] = a_s4[i][WORD_W-1];
			tag5.amag[i] = umag(a_s4[i]);
		end
		tag5.fneg = f_s4[WORD_W-1];
		tag5.fmag = umag(f_s4);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s5 <= tag5;
			s2_s5  <= s2_s4;
		end
	end

	// ---------------- square root: one root bit per stage
	sq_t              sq_q [SQ_STAGES];
	logic [SQ_STAGES-1:0] sq_v_q;
	sq_t              sq_in;

	always_comb begin
		sq_in.tag  = tag_s5;
		sq_in.rad  = s2_s5;
		sq_in.rem  = '0;
		sq_in.root = '0;
	end

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
		sq_t         cur, nxt;
		logic [WORD_W+3:0] t, cmp;
		if (k == 0) begin : g_first
			assign cur = sq_in;
		end else begin : g_next
			assign cur = sq_q[k-1];
		end
		always_comb begin
			t   = {cur.rem, cur.rad[2*WORD_W-1 -: 2]};
			cmp = {2'b00, cur.root, 2'b01};
			nxt = cur;
			nxt.rad = cur.rad << 2;
			if (t >= cmp) begin
				nxt.rem  = (WORD_W+2)'(t - cmp);
				nxt.root = {cur.root[WORD_W-2:0], 1'b1};
			end else begin
				nxt.rem  = t[WORD_W+1:0];
				nxt.root = {cur.root[WORD_W-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (adv) sq_q[k] <= nxt;
		end
	end

	// ---------------- round the root, pick the divisor
	tag_t              rnd_tag_q;
	logic [WORD_W-1:0] rnd_den_q;
	logic              rnd_v_q;
	tag_t              rtag;
	logic [WORD_W:0]   m33;
	logic [WORD_W-1:0] dm;
	satw_t             swm;

	always_comb begin
		m33  = {1'b0, sq_q[SQ_STAGES-1].root}
			+ (WORD_W+1)'(sq_q[SQ_STAGES-1].rem > (WORD_W+2)'(sq_q[SQ_STAGES-1].root));
		rtag = sq_q[SQ_STAGES-1].tag;
		swm  = sat_word(68'(m33));
		if (rtag.mode == MODE_MAG) begin
			rtag.res.sc  = swm.val;
			rtag.res.sat = swm.hit;
		end
		dm = (rtag.mode == MODE_DIV) ? rtag.fmag : m33[WORD_W-1:0];
		// keep the divisor nonzero; the error cases discard the quotient
		if (dm == '0) dm = {{(WORD_W-1){1'b0}}, 1'b1};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rnd_tag_q <= rtag;
			rnd_den_q <= dm;
		end
	end

	// ---------------- divider setup and restoring steps
	dv_t              dv_q [DV_STAGES+1];
	logic [DV_STAGES:0] dv_v_q;
	dv_t              dv_in;

	always_comb begin
		dv_in.tag = rnd_tag_q;
		dv_in.den = {rnd_den_q, 1'b0};
		for (int i = 0; i < 3; i++) begin
			dv_in.num[i] = NUM_W'({rnd_tag_q.amag[i], {(FRAC_W+1){1'b0}}}) + NUM_W'(rnd_den_q);
			dv_in.ovf[i] = (WORD_W+1)'(dv_in.num[i][NUM_W-1:WORD_W+1]) >= dv_in.den;
			dv_in.rem[i] = dv_in.ovf[i] ? '0
				: (WORD_W+1)'(dv_in.num[i][NUM_W-1:WORD_W+1]);
			dv_in.quo[i] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) dv_q[0] <= dv_in;
	end

	for (genvar j = 1; j <= DV_STAGES; j++) begin : g_dv
		dv_t           nxt;
		logic [WORD_W+1:0] t [3];
		always_comb begin
			nxt = dv_q[j-1];
			for (int i = 0; i < 3; i++) begin
				t[i] = {dv_q[j-1].rem[i], dv_q[j-1].num[i][DV_STAGES-j]};
				if (t[i] >= {1'b0, dv_q[j-1].den}) begin
					nxt.rem[i] = (WORD_W+1)'(t[i] - {1'b0, dv_q[j-1].den});
					nxt.quo[i] = {dv_q[j-1].quo[i][WORD_W-1:0], 1'b1};
				end else begin
					nxt.rem[i] = t[i][WORD_W:0];
					nxt.quo[i] = {dv_q[j-1].quo[i][WORD_W-1:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) dv_q[j] <= nxt;
		end
	end

	// ---------------- output register
	res_t            out_q;
	res_t            ores;
	dv_t             dl;
	logic            qneg;
	logic [WORD_W:0] lim;
	word_t           qv [3];
	logic            qsat;

	always_comb begin
		dl   = dv_q[DV_STAGES];
		ores = dl.tag.res;
		qsat = 1'b0;
		qneg = 1'b0;
		lim  = '0;
		for (int i = 0; i < 3; i++) begin
			qneg = dl.tag.aneg[i] ^ ((dl.tag.mode == MODE_DIV) & dl.tag.fneg);
			lim  = qneg ? ((WORD_W+1)'(1) << (WORD_W - 1))
				: (((WORD_W+1)'(1) << (WORD_W - 1)) - 1'b1);
			if (dl.ovf[i] || dl.quo[i] > lim) begin
				qv[i] = qneg ? word_t'(SAT_MIN[WORD_W-1:0]) : word_t'(SAT_MAX[WORD_W-1:0]);
				qsat  = 1'b1;
			end else begin
				qv[i] = qneg ? word_t'(-dl.quo[i][WORD_W-1:0]) : word_t'(dl.quo[i][WORD_W-1:0]);
			end
		end
		if ((dl.tag.mode == MODE_DIV || dl.tag.mode == MODE_NORM) && !dl.tag.res.err) begin
			ores.rx  = qv[0];
			ores.ry  = qv[1];
			ores.rz  = qv[2];
			ores.sat = qsat;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) out_q <= ores;
	end

	// ---------------- valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
			v_s5          <= 1'b0;
			sq_v_q        <= '0;
			rnd_v_q       <= 1'b0;
			dv_v_q        <= '0;
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			v_s1          <= s_axis_tvalid;
			v_s2          <= v_s1;
			v_s3          <= v_s2;
			v_s4          <= v_s3;
			v_s5          <= v_s4;
			sq_v_q        <= {sq_v_q[SQ_STAGES-2:0], v_s5};
			rnd_v_q       <= sq_v_q[SQ_STAGES-1];
			dv_v_q        <= {dv_v_q[DV_STAGES-1:0], rnd_v_q};
			m_axis_tvalid <= dv_v_q[DV_STAGES];
		end
	end

	assign m_axis_tdata = {out_q.sc, out_q.rz, out_q.ry, out_q.rx};
	assign m_axis_tuser = {out_q.err, out_q.sat};

`ifndef SYNTHESIS
	a_err_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
		else $error("error result also flagged as saturated");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
		else $error("error result carries nonzero data");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_q[0] |-> dv_q[0].den != '0)
		else $error("divider entered with zero divisor");

	a_mag_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_v_q && rnd_tag_q.mode == MODE_MAG |-> !rnd_tag_q.res.err)
		else $error("magnitude flagged an error");
`endif

endmodule

[sim/tb_vector3_alu_unit.sv]
// ----------------------------------------------------------------------------
// tb_vector3_alu_unit
// Self-checking bench for the pipelined Q16.16 vector unit. A local model
// predicts the result of every accepted transaction, and the results are
// checked in order, field by field. The run covers directed corner cases,
// output back-pressure, a drain pause and a long random stream with
// random idling on both sides.
// ----------------------------------------------------------------------------
module tb_vector3_alu_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import v3alu_pkg::*;

	typedef logic signed [127:0] wide_t;

	// mode in the lowest bits, then ax, ay, az, bx, by, bz, factor
	typedef struct packed {
		word_t      fct;
		word_t      bz;
		word_t      by;
		word_t      bx;
		word_t      az;
		word_t      ay;
		word_t      ax;
		logic [3:0] mode;
	} vec_op_t;

	localparam wide_t WORD_MAX = (wide_t'(1) <<< (WORD_W - 1)) - 1;
	localparam wide_t WORD_MIN = -(wide_t'(1) <<< (WORD_W - 1));
	localparam word_t W_MAX    = 32'sh7fff_ffff;
	localparam word_t W_MIN    = 32'sh8000_0000;
	localparam word_t ONE      = 32'sh0001_0000;
	localparam word_t NEG_ONE  = -32'sh0001_0000;
	localparam int    HOLD_LEN = 400;
	localparam int    WD_LIMIT = 5000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	res_t expected_q[$];
	int   mismatches;
	int   tx_max_gap;
	int   rx_max_gap;
	int   rx_hold;
	int   idle_cycles;

	vector3_alu_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------- prediction ----------------
	function automatic word_t clamp_word(input wide_t v, inout logic hit);
		if (v > WORD_MAX) begin
			hit = 1'b1;
			return W_MAX;
		end
		if (v < WORD_MIN) begin
			hit = 1'b1;
			return W_MIN;
		end
		return word_t'(v[WORD_W-1:0]);
	endfunction

	// round(x*y / 2^s), ties away from zero, magnitude capped at 2^32
	function automatic wide_t mul_round(input wide_t x, input wide_t y, input int s);
		logic         neg;
		logic [127:0] ux, uy, r;
		neg = (x < 0) != (y < 0);
		ux = (x < 0) ? -x : x;
		uy = (y < 0) ? -y : y;
		r = (ux * uy + (128'd1 << (s - 1))) >> s;
		if (r > (128'd1 << WORD_W))
			r = 128'd1 << WORD_W;
		return neg ? -wide_t'(r) : wide_t'(r);
	endfunction

	// round(num * 2^FRAC / d), ties away from zero
	function automatic wide_t div_round(input wide_t num, input logic [127:0] d,
			input logic dneg);
		logic [127:0] n, q;
		n = ((num < 0) ? -num : num) << FRAC_W;
		q = (2 * n + d) / (2 * d);
		return ((num < 0) != dneg) ? -wide_t'(q) : wide_t'(q);
	endfunction

	// round(sum / 2^FRAC), ties toward plus infinity
	function automatic wide_t sum_round(input wide_t p0, input wide_t p1, input wide_t p2);
		wide_t s;
		s = p0 + p1 + p2 + (wide_t'(1) <<< (FRAC_W - 1));
		return s >>> FRAC_W;
	endfunction

	function automatic logic [127:0] sqrt_round(input logic [127:0] v);
		logic [127:0] n, r, b;
		n = v;
		r = 0;
		b = 128'd1 << 126;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return (n > r) ? r + 1 : r;
	endfunction

	function automatic res_t vec_predict(input vec_op_t op);
		res_t         e;
		wide_t        a[3], b[3], r[3], f, d;
		logic [127:0] s2, m;
		logic         hit;
		a[0] = op.ax; a[1] = op.ay; a[2] = op.az;
		b[0] = op.bx; b[1] = op.by; b[2] = op.bz;
		f = op.fct;
		r[0] = 0; r[1] = 0; r[2] = 0;
		e = '0;
		hit = 1'b0;
		case (op.mode)
			MODE_ADD: for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
			MODE_SUB: for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
			MODE_NEG: for (int i = 0; i < 3; i++) r[i] = -a[i];
			MODE_SCALE: for (int i = 0; i < 3; i++) r[i] = mul_round(a[i], f, FRAC_W);
			MODE_DIV: begin
				if (f == 0)
					e.err = 1'b1;
				else
					for (int i = 0; i < 3; i++)
						r[i] = div_round(a[i], (f < 0) ? -f : f, f < 0);
			end
			MODE_DOT: e.sc = clamp_word(sum_round(a[0] * b[0], a[1] * b[1], a[2] * b[2]), hit);
			MODE_CROSS: begin
				r[0] = sum_round(a[1] * b[2], -(a[2] * b[1]), 0);
				r[1] = sum_round(a[2] * b[0], -(a[0] * b[2]), 0);
				r[2] = sum_round(a[0] * b[1], -(a[1] * b[0]), 0);
			end
			MODE_MAG, MODE_NORM: begin
				s2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
				m = sqrt_round(s2);
				if (op.mode == MODE_MAG)
					e.sc = clamp_word(wide_t'(m), hit);
				else if (s2 == 0)
					e.err = 1'b1;
				else
					for (int i = 0; i < 3; i++) r[i] = div_round(a[i], m, 1'b0);
			end
			MODE_REFL: begin
				d = sum_round(a[0] * b[0], a[1] * b[1], a[2] * b[2]);
				for (int i = 0; i < 3; i++) r[i] = a[i] - mul_round(d, b[i], FRAC_W - 1);
			end
			default: e.err = 1'b1;
		endcase
		e.rx = clamp_word(r[0], hit);
		e.ry = clamp_word(r[1], hit);
		e.rz = clamp_word(r[2], hit);
		e.sat = hit;
		return e;
	endfunction

	// ---------------- stimulus ----------------
	task automatic send_op(input vec_op_t op);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= {{(IN_DATA_W - $bits(vec_op_t)){1'b0}}, op};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_q.push_back(vec_predict(op));
	endtask

	task automatic send_fields(input logic [3:0] mode, input word_t ax, input word_t ay,
			input word_t az, input word_t bx, input word_t by, input word_t bz,
			input word_t fct);
		vec_op_t op;
		op = '{fct: fct, bz: bz, by: by, bx: bx, az: az, ay: ay, ax: ax, mode: mode};
		send_op(op);
	endtask

	function automatic word_t rand_word();
		case ($urandom_range(0, 5))
			0: return word_t'($urandom);
			1: return word_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
			2: return word_t'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
			3: begin
				case ($urandom_range(0, 5))
					0: return W_MAX;
					1: return W_MIN;
					2: return 0;
					3: return ONE;
					4: return NEG_ONE;
					default: return word_t'($urandom_range(0, 3)) - 1;
				endcase
			end
			default: return word_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	function automatic vec_op_t rand_op();
		vec_op_t op;
		op.mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
		                                        : 4'($urandom_range(0, 9));
		op.ax = rand_word(); op.ay = rand_word(); op.az = rand_word();
		op.bx = rand_word(); op.by = rand_word(); op.bz = rand_word();
		op.fct = rand_word();
		// unit-ish normal keeps reflect away from constant clamping
		if (op.mode == MODE_REFL && $urandom_range(0, 1)) begin
			op.bx = word_t'($urandom_range(0, 32'h0002_0000)) - ONE;
			op.by = word_t'($urandom_range(0, 32'h0002_0000)) - ONE;
			op.bz = word_t'($urandom_range(0, 32'h0002_0000)) - ONE;
		end
		if (op.mode == MODE_DIV && $urandom_range(0, 9) == 0)
			op.fct = 0;
		return op;
	endfunction

	// drop the offer and hold until every expected result has come
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_fields(MODE_ADD,   W_MAX, W_MIN, ONE, W_MAX, W_MIN, NEG_ONE, 0);
		send_fields(MODE_ADD,   1, -1, 0, -1, 1, 0, 0);
		send_fields(MODE_SUB,   W_MIN, W_MAX, 0, W_MAX, W_MIN, W_MIN, 0);
		send_fields(MODE_NEG,   W_MIN, W_MAX, NEG_ONE, 0, 0, 0, 0);
		send_fields(MODE_SCALE, W_MAX, W_MIN, ONE, 0, 0, 0, W_MAX);
		send_fields(MODE_SCALE, 3, -3, 32'sh0000_8000, 0, 0, 0, 32'sh0000_8000);
		send_fields(MODE_SCALE, W_MIN, 1, -1, 0, 0, 0, W_MIN);
		send_fields(MODE_DIV,   ONE, W_MAX, W_MIN, 0, 0, 0, 0);
		send_fields(MODE_DIV,   W_MIN, W_MAX, 1, 0, 0, 0, NEG_ONE);
		send_fields(MODE_DIV,   ONE, -3, W_MAX, 0, 0, 0, 3);
		send_fields(MODE_DIV,   W_MAX, W_MIN, 1, 0, 0, 0, W_MIN);
		send_fields(MODE_DOT,   W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 0);
		send_fields(MODE_DOT,   W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX, 0);
		send_fields(MODE_DOT,   1, 1, 1, 32'sh0000_8000, -32'sh0000_8000, 1, 0);
		send_fields(MODE_CROSS, ONE, 0, 0, 0, ONE, 0, 0);
		send_fields(MODE_CROSS, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, 0);
		send_fields(MODE_MAG,   W_MIN, W_MIN, W_MIN, 0, 0, 0, 0);
		send_fields(MODE_MAG,   0, 0, 0, 0, 0, 0, 0);
		send_fields(MODE_MAG,   3 * ONE, 4 * ONE, 0, 0, 0, 0, 0);
		send_fields(MODE_NORM,  0, 0, 0, 0, 0, 0, 0);
		send_fields(MODE_NORM,  3 * ONE, -4 * ONE, 0, 0, 0, 0, 0);
		send_fields(MODE_NORM,  W_MIN, W_MAX, 1, 0, 0, 0, 0);
		send_fields(MODE_REFL,  ONE, NEG_ONE, ONE, 0, ONE, 0, 0);
		send_fields(MODE_REFL,  W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, 0);
		send_fields(4'd10, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
		send_fields(4'd15, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX);
	endtask

	// stall the output for a long stretch while the input keeps offering
	task automatic test_backpressure();
		tx_max_gap = 0;
		rx_hold = HOLD_LEN;
		repeat (250) send_op(rand_op());
		tx_max_gap = 10;
	endtask

	// hold the input until the pipeline has emptied, then resume
	task automatic test_drain();
		repeat (20) send_op(rand_op());
		wait_drained();
		repeat (20) send_op(rand_op());
	endtask

	task automatic test_random();
		for (int seg = 0; seg < 10; seg++) begin
			tx_max_gap = (seg % 3 == 1) ? 0 : 10;
			rx_max_gap = (seg % 3 == 1) ? 0 : 10;
			repeat (165) send_op(rand_op());
		end
		tx_max_gap = 10;
		rx_max_gap = 10;
	endtask

	// ---------------- result checking ----------------
	initial begin
		int   gap;
		res_t got, want;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, rx_max_gap);
			if (rx_hold > 0) begin
				gap = rx_hold;
				rx_hold = 0;
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			got = '{rx: m_axis_tdata[31:0], ry: m_axis_tdata[63:32],
			        rz: m_axis_tdata[95:64], sc: m_axis_tdata[127:96],
			        sat: m_axis_tuser[0], err: m_axis_tuser[1]};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %p", got);
			end else begin
				want = expected_q.pop_front();
				if (got.rx !== want.rx || got.ry !== want.ry || got.rz !== want.rz ||
						got.sc !== want.sc || got.sat !== want.sat || got.err !== want.err) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	// watchdog: cycles without any transaction on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		mismatches    = 0;
		idle_cycles   = 0;
		tx_max_gap    = 10;
		rx_max_gap    = 10;
		rx_hold       = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_drain();
		test_random();
		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
